// ===== hdl/ebd_pkg.sv =====
package ebd_pkg;

    localparam int unsigned BUF_WORDS_DEF  = 4096;
    localparam int unsigned MAX_EVENTS_DEF = 64;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NUM_W   = 28;
    localparam int unsigned START_W = 12;
    localparam int unsigned LEN_W   = 13;

    localparam logic [31:0] NUM_MASK   = 32'h0fff_ffff;
    localparam logic [31:0] FLAG_MASK  = 32'hf000_0000;
    localparam logic [31:0] FLAG_GOOD  = 32'h1000_0000;
    localparam logic [31:0] TRAIL_MASK = 32'h000f_ffff;
    localparam logic [27:0] MIN_DEPTH  = 28'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last_word;
    } t_in_item;

    typedef struct packed {
        logic [START_W-1:0] event_start;
        logic [LEN_W-1:0]   event_length;
        logic [NUM_W-1:0]   event_number;
        logic               header_ok;
        logic               overflow;
        logic               last_event;
    } t_out_item;

    // one parsed event as held until the buffer's overflow status is known
    typedef struct packed {
        logic [START_W-1:0] event_start;
        logic [LEN_W-1:0]   event_length;
        logic [NUM_W-1:0]   event_number;
        logic               header_ok;
    } t_evt_entry;

    typedef enum logic [2:0] {
        RD_IP,
        RD_HDR,
        RD_TRL,
        RD_SCAN0,
        RD_SCAN_NEXT
    } t_rd_sel;

    typedef enum logic [1:0] {
        NEXT_END,
        NEXT_DEP,
        NEXT_SCAN
    } t_next_sel;

    typedef struct packed {
        logic      load;
        logic      parse_init;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      cap_num;
        logic      cap_hdr;
        logic      scan_init;
        logic      scan_step;
        logic      rec;
        t_next_sel next_sel;
        logic      emit_init;
        logic      emit_rd;
        logic      clear;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic hdr_avail;
        logic hdr_pass;
        logic trl_ok;
        logic scan_room;
        logic scan_stop;
        logic emit_last;
    } t_stat;

    function automatic logic is_trailer(input logic [31:0] w);
        is_trailer = ((w & TRAIL_MASK) == TRAIL_MASK);
    endfunction

endpackage

// ===== hdl/ebd_ctrl.sv =====
module ebd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_last_word,
    input  ebd_pkg::t_stat i_stat,
    output ebd_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_NUM,
        S_GOT_NUM,
        S_NO_HDR,
        S_GOT_HDR,
        S_GOT_TRL,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = ebd_pkg::RD_IP;
        o_cmd.next_sel = ebd_pkg::NEXT_END;
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_word) begin
                        o_cmd.parse_init = 1'b1;
                        n_state          = S_RD_NUM;
                    end
                end
            end
            S_RD_NUM: begin
                if (i_stat.more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ebd_pkg::RD_IP;
                    n_state      = S_GOT_NUM;
                end else begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_GOT_NUM: begin
                o_cmd.cap_num = 1'b1;
                if (i_stat.hdr_avail) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ebd_pkg::RD_HDR;
                    n_state      = S_GOT_HDR;
                end else begin
                    n_state = S_NO_HDR;
                end
            end
            S_NO_HDR: begin
                o_cmd.rec      = 1'b1;
                o_cmd.next_sel = ebd_pkg::NEXT_END;
                n_state        = S_RD_NUM;
            end
            S_GOT_HDR: begin
                o_cmd.cap_hdr = 1'b1;
                if (i_stat.hdr_pass) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = ebd_pkg::RD_TRL;
                    n_state      = S_GOT_TRL;
                end else if (i_stat.scan_room) begin
                    o_cmd.scan_init = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = ebd_pkg::RD_SCAN0;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.rec      = 1'b1;
                    o_cmd.next_sel = ebd_pkg::NEXT_END;
                    n_state        = S_RD_NUM;
                end
            end
            S_GOT_TRL: begin
                if (i_stat.trl_ok) begin
                    o_cmd.rec      = 1'b1;
                    o_cmd.next_sel = ebd_pkg::NEXT_DEP;
                    n_state        = S_RD_NUM;
                end else if (i_stat.scan_room) begin
                    o_cmd.scan_init = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = ebd_pkg::RD_SCAN0;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.rec      = 1'b1;
                    o_cmd.next_sel = ebd_pkg::NEXT_END;
                    n_state        = S_RD_NUM;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_stop) begin
                    o_cmd.rec      = 1'b1;
                    o_cmd.next_sel = ebd_pkg::NEXT_SCAN;
                    n_state        = S_RD_NUM;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = ebd_pkg::RD_SCAN_NEXT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_stat.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

    // busy tracks the idle state exactly
    a_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE))
        else $error("busy out of step with state");

    // a closing word always leads into parsing
    a_close_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start && i_last_word) |=> (r_state == S_RD_NUM))
        else $error("closing word did not start parsing");

    // scanning only follows a header check or another scan step
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ($past(r_state) == S_GOT_HDR ||
                                 $past(r_state) == S_GOT_TRL ||
                                 $past(r_state) == S_SCAN))
        else $error("scan entered from a wrong state");

endmodule

// ===== hdl/ebd_dpath.sv =====
module ebd_dpath #(
    parameter int unsigned BUF_WORDS  = ebd_pkg::BUF_WORDS_DEF,
    parameter int unsigned MAX_EVENTS = ebd_pkg::MAX_EVENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ebd_pkg::t_cmd      i_cmd,
    input  ebd_pkg::t_in_item  i_item,
    output ebd_pkg::t_stat     o_stat,
    output logic               o_strobe,
    output ebd_pkg::t_out_item o_result
);

    localparam int unsigned CW  = $clog2(BUF_WORDS + 1);
    localparam int unsigned AW  = $clog2(BUF_WORDS);
    localparam int unsigned EW  = $clog2(MAX_EVENTS + 1);
    localparam int unsigned EIW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int unsigned SW  = ((CW > ebd_pkg::NUM_W) ? CW : ebd_pkg::NUM_W) + 1;

    logic [ebd_pkg::WORD_W-1:0] r_mem [BUF_WORDS];
    ebd_pkg::t_evt_entry        r_rmem [MAX_EVENTS];

    logic [CW-1:0]               r_fill;
    logic                        r_drop;
    logic [CW-1:0]               r_ip;
    logic [EW-1:0]               r_ev;
    logic [CW-1:0]               r_start;
    logic [ebd_pkg::NUM_W-1:0]   r_num;
    logic [ebd_pkg::NUM_W-1:0]   r_dep;
    logic [CW-1:0]               r_ptr;
    logic [ebd_pkg::WORD_W-1:0]  r_rdata;
    logic                        r_ovf;
    logic [EW-1:0]               r_eidx;
    ebd_pkg::t_evt_entry         r_rent;
    logic                        r_strobe;
    logic                        r_out_last;

    logic [CW-1:0]               rd_addr;
    logic [CW-1:0]               n_next;
    logic [CW-1:0]               n_len;
    logic [ebd_pkg::NUM_W-1:0]   rd_dep;
    ebd_pkg::t_evt_entry         n_entry;

    assign rd_dep = r_rdata[ebd_pkg::NUM_W-1:0];

    // read address for the word store
    always_comb begin
        unique case (i_cmd.rd_sel)
            ebd_pkg::RD_IP:        rd_addr = r_ip;
            ebd_pkg::RD_HDR:       rd_addr = r_ip + 1'b1;
            ebd_pkg::RD_TRL:       rd_addr = r_start + CW'(rd_dep) - 1'b1;
            ebd_pkg::RD_SCAN0:     rd_addr = r_start + CW'(2);
            ebd_pkg::RD_SCAN_NEXT: rd_addr = r_ptr + 1'b1;
            default:               rd_addr = r_ip;
        endcase
    end

    always_comb begin
        unique case (i_cmd.next_sel)
            ebd_pkg::NEXT_END:  n_next = r_fill;
            ebd_pkg::NEXT_DEP:  n_next = r_start + CW'(r_dep);
            ebd_pkg::NEXT_SCAN: n_next = r_ptr + 1'b1;
            default:            n_next = r_fill;
        endcase
        n_len                 = n_next - r_start;
        n_entry.event_start   = ebd_pkg::START_W'(r_start);
        n_entry.event_length  = ebd_pkg::LEN_W'(n_len);
        n_entry.event_number  = r_num;
        n_entry.header_ok     = (i_cmd.next_sel == ebd_pkg::NEXT_DEP);
    end

    always_comb begin
        o_stat.more      = (r_ip < r_fill) && (r_ev < EW'(MAX_EVENTS));
        o_stat.hdr_avail = ({1'b0, r_ip} + 1'b1) < {1'b0, r_fill};
        o_stat.hdr_pass  = ((r_rdata & ebd_pkg::FLAG_MASK) == ebd_pkg::FLAG_GOOD) &&
                           (rd_dep >= ebd_pkg::MIN_DEPTH) &&
                           ((SW'(r_start) + SW'(rd_dep)) <= SW'(r_fill));
        o_stat.trl_ok    = ebd_pkg::is_trailer(r_rdata);
        o_stat.scan_room = ({1'b0, r_start} + (CW + 1)'(2)) < {1'b0, r_fill};
        o_stat.scan_stop = ebd_pkg::is_trailer(r_rdata) ||
                           (({1'b0, r_ptr} + 1'b1) == {1'b0, r_fill});
        o_stat.emit_last = (EW'(r_eidx + 1'b1) == r_ev);
    end

    // word store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_fill < CW'(BUF_WORDS))) begin
            r_mem[r_fill[AW-1:0]] <= i_item.word;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr[AW-1:0]];
        end
    end

    // event store, written during parsing, read back during emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.rec) begin
            r_rmem[r_ev[EIW-1:0]] <= n_entry;
        end
        if (i_cmd.emit_rd) begin
            r_rent <= r_rmem[r_eidx[EIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_drop   <= 1'b0;
            r_ip     <= '0;
            r_ev     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit_rd;
            if (i_cmd.clear) begin
                r_fill <= '0;
                r_drop <= 1'b0;
                r_ip   <= '0;
                r_ev   <= '0;
            end else begin
                if (i_cmd.load) begin
                    if (r_fill < CW'(BUF_WORDS)) begin
                        r_fill <= r_fill + 1'b1;
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                if (i_cmd.parse_init) begin
                    r_ip <= '0;
                    r_ev <= '0;
                end else if (i_cmd.rec) begin
                    r_ip <= n_next;
                    r_ev <= r_ev + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_num) begin
            r_start <= r_ip;
            r_num   <= r_rdata[ebd_pkg::NUM_W-1:0];
        end
        if (i_cmd.cap_hdr) begin
            r_dep <= rd_dep;
        end
        if (i_cmd.scan_init) begin
            r_ptr <= r_start + CW'(2);
        end else if (i_cmd.scan_step) begin
            r_ptr <= r_ptr + 1'b1;
        end
        if (i_cmd.emit_init) begin
            r_ovf  <= r_drop || (r_ip < r_fill);
            r_eidx <= '0;
        end else if (i_cmd.emit_rd) begin
            r_eidx <= r_eidx + 1'b1;
        end
        if (i_cmd.emit_rd) begin
            r_out_last <= o_stat.emit_last;
        end
    end

    assign o_strobe              = r_strobe;
    assign o_result.event_start  = r_rent.event_start;
    assign o_result.event_length = r_rent.event_length;
    assign o_result.event_number = r_rent.event_number;
    assign o_result.header_ok    = r_rent.header_ok;
    assign o_result.overflow     = r_ovf;
    assign o_result.last_event   = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BUF_WORDS))
        else $error("fill count past buffer size");

    a_ev_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev <= EW'(MAX_EVENTS))
        else $error("event count past limit");

    a_ip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ip <= r_fill)
        else $error("parse pointer past buffer end");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_out_last) |=> !r_strobe)
        else $error("result after last event of buffer");

endmodule

// ===== hdl/event_block_deframer.sv =====
// loading: one word per cycle while o_busy is low; a word is taken when i_start is high
// parsing: per event the number word, then the header word and, for a good header, the
//   trailer word are read; a failed check starts a resync scan for a trailer-like word
// emit: one result per cycle after a setup step, read from the event store via a register
// reset: synchronous active-low i_rst_n empties the buffer, clears r_drop and the strobe;
//   results cannot be held off, each strobe lasts one cycle
module event_block_deframer #(
    parameter int unsigned BUF_WORDS  = ebd_pkg::BUF_WORDS_DEF,
    parameter int unsigned MAX_EVENTS = ebd_pkg::MAX_EVENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  ebd_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output ebd_pkg::t_out_item o_result
);

    // control and status between sequencer and datapath
    ebd_pkg::t_cmd  cmd;
    ebd_pkg::t_stat stat;

    // sequencer: load, per-event header and trailer checks, scan, emit
    ebd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_last_word (i_item.last_word),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    // datapath: word store, event store, pointers and counters
    ebd_dpath #(
        .BUF_WORDS  (BUF_WORDS),
        .MAX_EVENTS (MAX_EVENTS)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== sim/event_block_deframer_checker.sv =====
`timescale 1ns / 100ps

module event_block_deframer_checker #(
    parameter int unsigned BUF_WORDS  = ebd_pkg::BUF_WORDS_DEF,
    parameter int unsigned MAX_EVENTS = ebd_pkg::MAX_EVENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  ebd_pkg::t_in_item  i_item,
    input  logic               i_strobe,
    input  ebd_pkg::t_out_item i_result,
    output int                 o_mismatches,
    output int                 o_pending
);

    logic [31:0]        held_words [BUF_WORDS];
    int unsigned        fill_words;
    logic               words_dropped;
    ebd_pkg::t_out_item expected_events [$];

    // walk the held buffer and queue one expected result per event
    function automatic void split_into_events();
        int unsigned        n;
        int unsigned        ip;
        int unsigned        first;
        int unsigned        next;
        int unsigned        depth;
        int unsigned        count;
        logic [31:0]        hdr;
        logic [31:0]        scanned;
        logic               trusted;
        logic               cut_short;
        ebd_pkg::t_out_item found [$];
        ebd_pkg::t_out_item evt;

        n     = fill_words;
        ip    = 0;
        count = 0;
        while (ip < n && count < MAX_EVENTS) begin
            first   = ip;
            trusted = 1'b0;
            if (first + 1 < n) begin
                hdr   = held_words[first + 1];
                depth = hdr & ebd_pkg::NUM_MASK;
                trusted = ((hdr & ebd_pkg::FLAG_MASK) == ebd_pkg::FLAG_GOOD) &&
                          depth >= 3 && first + depth <= n &&
                          (&held_words[first + depth - 1][19:0]);
                if (trusted) begin
                    next = first + depth;
                end else begin
                    // resync: stop just past the first trailer-like word
                    next = first + 2;
                    while (next < n) begin
                        scanned = held_words[next];
                        next++;
                        if (&scanned[19:0])
                            break;
                    end
                end
            end else begin
                next = n;
            end
            if (next > n)
                next = n;

            evt.event_start  = first[ebd_pkg::START_W-1:0];
            evt.event_length = ebd_pkg::LEN_W'(next - first);
            evt.event_number = held_words[first][ebd_pkg::NUM_W-1:0];
            evt.header_ok    = trusted;
            evt.overflow     = 1'b0;
            evt.last_event   = 1'b0;
            found.push_back(evt);
            ip = next;
            count++;
        end

        cut_short = words_dropped || ip < n;
        foreach (found[k]) begin
            found[k].overflow   = cut_short;
            found[k].last_event = (k == found.size() - 1);
            expected_events.push_back(found[k]);
        end
        fill_words    = 0;
        words_dropped = 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            o_mismatches = o_mismatches + 1;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        ebd_pkg::t_out_item want;
        if (!i_rst_n) begin
            fill_words    = 0;
            words_dropped = 1'b0;
            o_mismatches  = 0;
            expected_events.delete();
        end else begin
            if (i_start && !i_busy) begin
                if (fill_words < BUF_WORDS) begin
                    held_words[fill_words] = i_item.word;
                    fill_words++;
                end else begin
                    words_dropped = 1'b1;
                end
                if (i_item.last_word)
                    split_into_events();
            end
            if (i_strobe) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %0h",
                             $time, i_result);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_start", 32'(want.event_start),
                                32'(i_result.event_start));
                    check_field("event_length", 32'(want.event_length),
                                32'(i_result.event_length));
                    check_field("event_number", 32'(want.event_number),
                                32'(i_result.event_number));
                    check_field("header_ok", 32'(want.header_ok),
                                32'(i_result.header_ok));
                    check_field("overflow", 32'(want.overflow),
                                32'(i_result.overflow));
                    check_field("last_event", 32'(want.last_event),
                                32'(i_result.last_event));
                end
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// ===== sim/event_block_deframer_tb.sv =====
`timescale 1ns / 100ps

module event_block_deframer_tb;

    localparam int unsigned BUF_WORDS      = ebd_pkg::BUF_WORDS_DEF;
    localparam int unsigned MAX_EVENTS     = ebd_pkg::MAX_EVENTS_DEF;
    // parsing the longest buffer is the longest quiet stretch
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 50;
    localparam int          RANDOM_WORDS   = 150;

    // ways a random event is made unreliable
    typedef enum int {
        BAD_FLAG,
        SHORT_DEPTH,
        DEPTH_PAST_END,
        BAD_TRAILER
    } t_damage;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    ebd_pkg::t_in_item  i_item;
    logic               o_strobe;
    ebd_pkg::t_out_item o_result;

    int          mismatch_count;
    int          events_outstanding;
    int          idle_cycles = 0;
    int          random_words_sent;
    logic        no_gaps;
    logic [31:0] frame_words [$];

    event_block_deframer #(
        .BUF_WORDS  (BUF_WORDS),
        .MAX_EVENTS (MAX_EVENTS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // predicts the event results and compares them as they come out
    event_block_deframer_checker #(
        .BUF_WORDS  (BUF_WORDS),
        .MAX_EVENTS (MAX_EVENTS)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_item       (i_item),
        .i_strobe     (o_strobe),
        .i_result     (o_result),
        .o_mismatches (mismatch_count),
        .o_pending    (events_outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog: any accepted request or result strobe counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request: optional random gap, then hold start until the block takes it
    // start stays high on return so a back-to-back request needs no second assignment
    task automatic send_word(input logic [31:0] w, input logic lw);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= '{word: w, last_word: lw};
        do @(posedge i_clk); while (o_busy);
    endtask

    // send the assembled buffer, closing it on its final word
    task automatic send_frame();
        no_gaps = ($urandom_range(0, 3) == 0);
        foreach (frame_words[k])
            send_word(frame_words[k], k == frame_words.size() - 1);
        frame_words.delete();
    endtask

    // hold off new requests until every predicted event has come out
    task automatic wait_drained();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (events_outstanding != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // event number word, trusted header, body without trailer pattern, trailer
    task automatic add_good_event(input int unsigned depth);
        frame_words.push_back($urandom);
        frame_words.push_back(ebd_pkg::FLAG_GOOD | depth);
        repeat (depth - 3)
            frame_words.push_back($urandom & ~32'h1);
        frame_words.push_back($urandom | ebd_pkg::TRAIL_MASK);
    endtask

    task automatic add_broken_event(input t_damage damage);
        logic [31:0] hdr;
        int unsigned depth;
        depth = $urandom_range(3, 8);
        frame_words.push_back($urandom);
        unique case (damage)
            BAD_FLAG: begin
                hdr = $urandom;
                if ((hdr & ebd_pkg::FLAG_MASK) == ebd_pkg::FLAG_GOOD)
                    hdr ^= 32'h8000_0000;
                frame_words.push_back(hdr);
            end
            SHORT_DEPTH: begin
                frame_words.push_back(ebd_pkg::FLAG_GOOD | $urandom_range(0, 2));
            end
            DEPTH_PAST_END: begin
                frame_words.push_back(ebd_pkg::FLAG_GOOD | ($urandom & ebd_pkg::NUM_MASK) |
                                      32'h0000_1000);
            end
            default: begin
                // header looks fine but the closing word is not a trailer
                frame_words.push_back(ebd_pkg::FLAG_GOOD | depth);
                repeat (depth - 2)
                    frame_words.push_back($urandom & ~32'h1);
            end
        endcase
        // noise with some trailer-like words for the resync scan to find
        repeat ($urandom_range(0, 4))
            frame_words.push_back(($urandom_range(0, 2) == 0) ?
                                  ($urandom | ebd_pkg::TRAIL_MASK) : $urandom);
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        no_gaps = 1'b0;
        random_words_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone word: event with no header word, length 1, all-ones number
        frame_words.push_back(32'hffff_ffff);
        send_frame();

        // trusted minimum depth, bad flag with resync, short depth, depth past the end
        // with no trailer left so the scan runs to the buffer end
        frame_words = '{32'h0000_0001, 32'h1000_0003, 32'habcf_ffff,
                        32'hf000_0002, 32'h2000_0004, 32'h0000_0000, 32'h123f_ffff,
                        32'h0fff_ffff, 32'h1000_0002, 32'h000f_fffe, 32'h000f_ffff,
                        32'h0000_0005, 32'h1000_0010, 32'h0000_0000};
        send_frame();

        // right depth but wrong trailer, then an event on the last word
        frame_words = '{32'h0000_0007, 32'h1000_0004, 32'h0000_0000, 32'h000f_fffe,
                        32'hffff_ffff, 32'h0000_0008};
        send_frame();

        // pause until everything so far has come out
        wait_drained();

        // one event past the limit: words left unparsed
        repeat (MAX_EVENTS + 1) add_good_event(3);
        send_frame();

        // random buffers, mostly well-formed events with some damage mixed in
        while (random_words_sent < RANDOM_WORDS) begin
            repeat ($urandom_range(1, 6)) begin
                if ($urandom_range(0, 9) < 7)
                    add_good_event($urandom_range(3, 8));
                else
                    add_broken_event(t_damage'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 4) == 0)
                frame_words.push_back($urandom);
            random_words_sent += frame_words.size();
            send_frame();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
